/* sv/bbd_pkg.sv */
// Shared types and constants for the BGGR bilinear demosaic block.
`default_nettype none
package bbd_pkg;
  localparam int PIX_W          = 8;
  localparam int FW_W           = 12;
  localparam int FH_W           = 13;
  localparam int MIN_SIZE       = 4;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam logic [FW_W-1:0] FW_RESET = 12'd1920;
  localparam logic [FH_W-1:0] FH_RESET = 13'd1080;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int Q_DEPTH = 2;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_MAIN     = 2'd0,
    KIND_ROW_END  = 2'd1,
    KIND_LAST_ROW = 2'd2,
    KIND_CORNER   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [8:0][PIX_W-1:0] pix;
    logic                  r_odd;
    logic                  col0;
    logic                  c_is1;
    logic                  col_end;
    logic                  last_row;
    logic                  top_mirror;
  } job_t;
endpackage
`default_nettype wire

/* sv/bbd_front.sv */
// Front end: input acceptance, line stores, 3x3 window and job classification.
`default_nettype none
module bbd_front import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [WW-1:0]    width_i,
  input  wire logic [HW-1:0]    height_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [PIX_W-1:0] raw_pixel_i,
  output logic                  push_o,
  output job_t                  job_o,
  input  wire logic             q_ready_i
);
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic               p_valid_q, p_valid_d;
  logic [PIX_W-1:0]   p_pix_q;
  logic [CW-1:0]      p_col_q, col_q, col_d, acc_col;
  logic [RW-1:0]      p_row_q, row_q, row_d, acc_row;
  logic [8:0][PIX_W-1:0] win_q, win_d;
  logic               accept, advance, emit;
  logic               wrap_pre;
  logic [RW:0]        row_tmp, row_inc;
  logic [CW:0]        col_inc;

  assign emit    = (p_row_q != '0) && (p_col_q != '0);
  assign advance = p_valid_q && (!emit || q_ready_i);
  assign in_stall_o = p_valid_q && !advance;
  assign accept  = in_valid_i && !in_stall_o;
  assign push_o  = advance && emit;

  always_comb begin
    wrap_pre = WW'(col_q) >= width_i;
    acc_col  = wrap_pre ? '0 : col_q;
    row_tmp  = wrap_pre ? {1'b0, row_q} + (RW+1)'(1) : {1'b0, row_q};
    acc_row  = (HW'(row_tmp) >= height_i) ? '0 : row_tmp[RW-1:0];
    col_inc  = {1'b0, acc_col} + (CW+1)'(1);
    row_inc  = {1'b0, acc_row} + (RW+1)'(1);
    if (WW'(col_inc) >= width_i) begin
      col_d = '0;
      row_d = (HW'(row_inc) >= height_i) ? '0 : row_inc[RW-1:0];
    end else begin
      col_d = col_inc[CW-1:0];
      row_d = acc_row;
    end
    p_valid_d = accept ? 1'b1 : (advance ? 1'b0 : p_valid_q);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]     = win_q[k*3+1];
      win_d[k*3+1]   = win_q[k*3+2];
    end
    win_d[2] = rd_q[2*PIX_W-1:PIX_W];
    win_d[5] = rd_q[PIX_W-1:0];
    win_d[8] = p_pix_q;
    job_o.pix        = win_d;
    job_o.r_odd      = ~p_row_q[0];
    job_o.col0       = p_col_q[0];
    job_o.c_is1      = p_col_q == CW'(1);
    job_o.col_end    = WW'(p_col_q) == width_i - WW'(1);
    job_o.last_row   = HW'(p_row_q) == height_i - HW'(1);
    job_o.top_mirror = p_row_q == RW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
      win_q     <= '0;
    end else begin
      p_valid_q <= p_valid_d;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (advance) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_pix_q <= raw_pixel_i;
      p_col_q <= acc_col;
      p_row_q <= acc_row;
      rd_q    <= line_mem[acc_col];
    end
    if (advance) begin
      line_mem[p_col_q] <= {rd_q[PIX_W-1:0], p_pix_q};
    end
  end
endmodule
`default_nettype wire

/* sv/bbd_queue.sv */
// Two-entry job queue between front end and back end.
`default_nettype none
module bbd_queue import bbd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  output logic      ready_o,
  output logic      valid_o,
  output job_t      job_o,
  input  wire logic pop_i
);
  job_t       store_q [Q_DEPTH];
  logic       wr_q, rd_q;
  logic [1:0] count_q;

  assign valid_o = count_q != 2'd0;
  assign ready_o = (count_q != 2'(Q_DEPTH)) || pop_i;
  assign job_o   = store_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) store_q[wr_q] <= job_i;
  end
endmodule
`default_nettype wire

/* sv/bbd_back.sv */
// Back end: expands each job into its output pixels and holds the output register.
`default_nettype none
module bbd_back import bbd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic head_valid_i,
  input  job_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output logic [PIX_W-1:0] red_o,
  output logic [PIX_W-1:0] green_o,
  output logic [PIX_W-1:0] blue_o,
  output logic      end_of_row_o,
  output logic      end_of_frame_o,
  output logic      last_of_run_o
);
  kind_e      kind_q, kind_d;
  logic       load, done;
  logic       orow_odd, ocol_odd, first_col, last_col, eor, eof;
  logic [1:0] wc, lc, rc, top, mid, bot;
  logic [PIX_W-1:0] cv, red, green, blue;
  logic [PIX_W+1:0] cross_sum, diag;
  logic [PIX_W:0]   vert, horz;

  function automatic logic [PIX_W-1:0] px(job_t j, logic [1:0] r, logic [1:0] c);
    logic [3:0] idx;
    idx = 4'(r) * 4'd3 + 4'(c);
    return j.pix[idx];
  endfunction

  assign load  = head_valid_i && (!out_valid_o || !out_stall_i);

  always_comb begin
    kind_d = KIND_MAIN;
    done   = 1'b1;
    case (kind_q)
      KIND_MAIN: begin
        if (head_i.col_end) begin
          kind_d = KIND_ROW_END; done = 1'b0;
        end else if (head_i.last_row) begin
          kind_d = KIND_LAST_ROW; done = 1'b0;
        end
      end
      KIND_ROW_END: begin
        if (head_i.last_row) begin
          kind_d = KIND_LAST_ROW; done = 1'b0;
        end
      end
      KIND_LAST_ROW: begin
        if (head_i.col_end) begin
          kind_d = KIND_CORNER; done = 1'b0;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
    pop_o = load && done;
  end

  always_comb begin
    orow_odd  = head_i.r_odd;
    ocol_odd  = ~head_i.col0;
    wc        = 2'd1;
    first_col = head_i.c_is1;
    last_col  = 1'b0;
    top       = head_i.top_mirror ? 2'd2 : 2'd0;
    mid       = 2'd1;
    bot       = 2'd2;
    eor       = 1'b0;
    eof       = 1'b0;
    case (kind_q)
      KIND_MAIN: begin
      end
      KIND_ROW_END: begin
        ocol_odd = 1'b1; wc = 2'd2; first_col = 1'b0; last_col = 1'b1; eor = 1'b1;
      end
      KIND_LAST_ROW: begin
        orow_odd = 1'b1; top = 2'd1; mid = 2'd2; bot = 2'd1;
      end
      default: begin
        orow_odd = 1'b1; ocol_odd = 1'b1; wc = 2'd2; first_col = 1'b0; last_col = 1'b1;
        top = 2'd1; mid = 2'd2; bot = 2'd1; eor = 1'b1; eof = 1'b1;
      end
    endcase
    lc    = first_col ? wc + 2'd1 : wc - 2'd1;
    rc    = last_col ? wc - 2'd1 : wc + 2'd1;
    cv    = px(head_i, mid, wc);
    cross_sum = (PIX_W+2)'(px(head_i, top, wc)) + (PIX_W+2)'(px(head_i, bot, wc))
              + (PIX_W+2)'(px(head_i, mid, lc)) + (PIX_W+2)'(px(head_i, mid, rc));
    diag  = (PIX_W+2)'(px(head_i, top, lc)) + (PIX_W+2)'(px(head_i, top, rc))
          + (PIX_W+2)'(px(head_i, bot, lc)) + (PIX_W+2)'(px(head_i, bot, rc));
    vert  = (PIX_W+1)'(px(head_i, top, wc)) + (PIX_W+1)'(px(head_i, bot, wc));
    horz  = (PIX_W+1)'(px(head_i, mid, lc)) + (PIX_W+1)'(px(head_i, mid, rc));
    if (!orow_odd && !ocol_odd) begin
      blue = cv; green = cross_sum[PIX_W+1:2]; red = diag[PIX_W+1:2];
    end else if (orow_odd && ocol_odd) begin
      red = cv; green = cross_sum[PIX_W+1:2]; blue = diag[PIX_W+1:2];
    end else if (!orow_odd) begin
      green = cv; red = vert[PIX_W:1]; blue = horz[PIX_W:1];
    end else begin
      green = cv; red = horz[PIX_W:1]; blue = vert[PIX_W:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_MAIN;
      out_valid_o <= 1'b0;
    end else begin
      if (load) begin
        kind_q      <= kind_d;
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      red_o          <= red;
      green_o        <= green;
      blue_o         <= blue;
      end_of_row_o   <= eor;
      end_of_frame_o <= eof;
      last_of_run_o  <= done;
    end
  end
endmodule
`default_nettype wire

/* sv/bayer_bggr8_bilinear_demosaic.sv */
// Top level: BGGR 8-bit bilinear demosaic with APB size registers.
// Throughput: one raw pixel per cycle unless stalled; the back end gives one result per cycle
// while out_stall_i is low, so inputs that cause two or four results can stall the input.
// Path: a pixel's result is formed once the input is one row plus one pixel further on; the job
// then passes the pixel and line store read registers and the job queue into the output register.
// Reset: sizes return to 1920 x 1080, window and position clear; line stores are not cleared.
`default_nettype none
module bayer_bggr8_bilinear_demosaic import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [PIX_W-1:0]  raw_pixel_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [PIX_W-1:0]       red_o,
  output logic [PIX_W-1:0]       green_o,
  output logic [PIX_W-1:0]       blue_o,
  output logic                   end_of_row_o,
  output logic                   end_of_frame_o,
  output logic                   last_of_run_o
);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  logic [31:0]     w_full, h_full;
  logic [WW-1:0]   width;
  logic [HW-1:0]   height;
  logic            wr_en;
  logic            push, q_ready, head_valid, pop;
  job_t            job, head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_FRAME_WIDTH:  prdata = DATA_W'(fw_q);
      REG_FRAME_HEIGHT: prdata = DATA_W'(fh_q);
      default:          prdata = '0;
    endcase
    w_full = (32'(fw_q) < 32'(MIN_SIZE)) ? 32'(MIN_SIZE)
           : ((32'(fw_q) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(fw_q));
    h_full = (32'(fh_q) < 32'(MIN_SIZE)) ? 32'(MIN_SIZE)
           : ((32'(fh_q) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(fh_q));
    width  = w_full[WW-1:0] & ~WW'(1);
    height = h_full[HW-1:0] & ~HW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_RESET;
      fh_q <= FH_RESET;
    end else if (wr_en) begin
      if (reg_idx_e'(paddr[2]) == REG_FRAME_WIDTH) fw_q <= pwdata[FW_W-1:0];
      else fh_q <= pwdata[FH_W-1:0];
    end
  end

  bbd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i, .rst_ni,
    .width_i(width), .height_i(height),
    .in_valid_i, .in_stall_o, .raw_pixel_i,
    .push_o(push), .job_o(job), .q_ready_i(q_ready)
  );

  bbd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .job_i(job), .ready_o(q_ready),
    .valid_o(head_valid), .job_o(head), .pop_i(pop)
  );

  bbd_back u_back (
    .clk_i, .rst_ni,
    .head_valid_i(head_valid), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_stall_i,
    .red_o, .green_o, .blue_o, .end_of_row_o, .end_of_frame_o, .last_of_run_o
  );

  a_eof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> end_of_row_o)
    else $error("end of frame without end of row");
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> last_of_run_o)
    else $error("end of frame not last of run");
  a_push_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> q_ready)
    else $error("job pushed into full queue");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty queue");
endmodule
`default_nettype wire
